>>> rtl/bdpre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte diff patch encoder package
// Shared constants, command types, sequencer states and byte helpers.
// ----------------------------------------------------------------------------
package bdpre_pkg;

    localparam int MAX_RUN_DEF = 32;
    localparam int RUN_CAP     = 41;
    localparam int CNT_W       = 6;
    localparam int WORD_W      = 32;
    localparam int HDR_BYTES   = 5;
    localparam int WORD_BYTES  = 4;
    localparam int EOF_BYTES   = 3;

    localparam logic REG_BASE_LEN = 1'b0;
    localparam logic REG_NEW_LEN  = 1'b1;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_F = 8'h46;

    typedef struct packed {
        logic              err;
        logic              hdr;
        logic              flush;
        logic              eof;
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] start;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_ERR,
        ST_OFS,
        ST_LEN,
        ST_DATA,
        ST_EOF
    } t_bk_state;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = CH_P;
            3'd1:    ch = CH_A;
            3'd2:    ch = CH_T;
            3'd3:    ch = CH_C;
            3'd4:    ch = CH_H;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] eof_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_E;
            2'd1:    ch = CH_O;
            2'd2:    ch = CH_F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Big-endian byte select: index 0 is the most significant byte.
    function automatic logic [7:0] word_byte(input logic [WORD_W-1:0] word,
                                             input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

>>> rtl/byte_diff_patch_record_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte diff patch record encoder
// Result path: command queue, back-end state register, output register.
// Throughput: input beats are taken one per cycle while the command queue has
// room and the run bank being filled is not still being read by the back end;
// the back end pops each command in its idle state, then sends its patch bytes.
// Reset: synchronous active-low reset clears all control state; no clear pass.
// ----------------------------------------------------------------------------
module byte_diff_patch_record_encoder_core #(
    parameter int MAX_RUN = bdpre_pkg::MAX_RUN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [bdpre_pkg::WORD_W-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_base_byte,
    input  logic [7:0]                   i_new_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_end_of_batch,
    output logic                         o_end_of_patch,
    output logic                         o_error_flag
);

    localparam int RUN_LIMIT = (MAX_RUN < bdpre_pkg::RUN_CAP) ? MAX_RUN : bdpre_pkg::RUN_CAP;
    localparam int IDX_W     = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    bdpre_pkg::t_cmd     q_in_cmd;
    bdpre_pkg::t_cmd     q_out_cmd;
    bdpre_pkg::t_release bank_release;
    logic                ram_wr_en;
    logic [IDX_W:0]      ram_wr_addr;
    logic [7:0]          ram_wr_data;
    logic [IDX_W:0]      ram_rd_addr;
    logic [7:0]          ram_rd_data;

    bdpre_front #(
        .RUN_LIMIT (RUN_LIMIT),
        .IDX_W     (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_base_byte (i_base_byte),
        .i_new_byte  (i_new_byte),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd),
        .i_q_full    (q_full),
        .i_release   (bank_release),
        .o_wr_en     (ram_wr_en),
        .o_wr_addr   (ram_wr_addr),
        .o_wr_data   (ram_wr_data)
    );

    bdpre_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_run_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    bdpre_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    bdpre_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (q_out_cmd),
        .o_pop          (q_pop),
        .o_rd_addr      (ram_rd_addr),
        .i_rd_data      (ram_rd_data),
        .o_release      (bank_release),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_end_of_batch (o_end_of_batch),
        .o_end_of_patch (o_end_of_patch),
        .o_error_flag   (o_error_flag)
    );

endmodule

>>> rtl/bdpre_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdpre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bdpre_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patch encoder front end
// Holds the length registers and run state, classifies each input beat and
// issues emit commands. Run bytes go to one of two RAM banks; a bank that the
// back end is still reading holds off new input.
// ----------------------------------------------------------------------------
module bdpre_front #(
    parameter int RUN_LIMIT = 32,
    parameter int IDX_W     = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bdpre_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_base_byte,
    input  logic [7:0]                    i_new_byte,
    output logic                          o_push,
    output bdpre_pkg::t_cmd               o_cmd,
    input  logic                          i_q_full,
    input  bdpre_pkg::t_release           i_release,
    output logic                          o_wr_en,
    output logic [IDX_W:0]                o_wr_addr,
    output logic [7:0]                    o_wr_data
);

    localparam logic [bdpre_pkg::CNT_W-1:0] LIMIT = bdpre_pkg::CNT_W'(RUN_LIMIT);

    logic [bdpre_pkg::WORD_W-1:0] r_base_len;
    logic [bdpre_pkg::WORD_W-1:0] r_new_len;
    logic [bdpre_pkg::WORD_W-1:0] r_pos;
    logic [bdpre_pkg::WORD_W-1:0] r_run_start;
    logic [bdpre_pkg::CNT_W-1:0]  r_run_count;
    logic                         r_hdr_sent;
    logic                         r_halted;
    logic                         r_bank;
    logic [1:0]                   r_busy;
    logic [1:0]                   n_busy;

    logic                         w_accept;
    logic                         w_active;
    logic                         w_last;
    logic                         w_in_base;
    logic                         w_base_end;
    logic                         w_same;
    logic                         w_err;
    logic                         w_flush;
    logic                         w_do_flush;
    logic [bdpre_pkg::WORD_W-1:0] w_start;
    logic [bdpre_pkg::CNT_W-1:0]  w_cnt_inc;

    assign o_ready  = !i_q_full && !r_busy[r_bank];
    assign w_accept = i_valid && o_ready;
    assign w_active = w_accept && !r_halted;

    assign w_last     = (r_pos == r_new_len - 32'd1);
    assign w_in_base  = (r_pos < r_base_len);
    assign w_base_end = (r_pos == r_base_len - 32'd1);
    assign w_same     = w_in_base && (i_base_byte == i_new_byte);
    assign w_err      = !r_hdr_sent && (r_base_len > r_new_len);
    assign w_start    = (r_run_count == '0) ? r_pos : r_run_start;
    assign w_cnt_inc  = r_run_count + bdpre_pkg::CNT_W'(1);

    // An equal byte closes the open run; a differing byte extends it and may
    // close it at the limit, at the last position or at the base end.
    assign w_flush = w_same ? (r_run_count != '0)
                            : ((w_cnt_inc >= LIMIT) || w_last || (w_in_base && w_base_end));
    assign w_do_flush = w_active && !w_err && w_flush;

    always_comb begin
        o_cmd.err   = w_err;
        o_cmd.hdr   = !r_hdr_sent;
        o_cmd.flush = !w_err && w_flush;
        o_cmd.eof   = !w_err && w_last;
        o_cmd.bank  = r_bank;
        o_cmd.count = w_same ? r_run_count : w_cnt_inc;
        o_cmd.start = w_same ? r_run_start : w_start;
    end

    assign o_push    = w_active && (w_err || !r_hdr_sent || w_flush || w_last);
    assign o_wr_en   = w_active && !w_err && !w_same;
    assign o_wr_addr = {r_bank, r_run_count[IDX_W-1:0]};
    assign o_wr_data = i_new_byte;

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (w_do_flush) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len  <= '0;
            r_new_len   <= 32'd1;
            r_pos       <= '0;
            r_run_start <= '0;
            r_run_count <= '0;
            r_hdr_sent  <= 1'b0;
            r_halted    <= 1'b0;
            r_bank      <= 1'b0;
            r_busy      <= '0;
        end else begin
            r_busy <= n_busy;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bdpre_pkg::REG_BASE_LEN: r_base_len <= i_cfg_data;
                    default:                 r_new_len  <= i_cfg_data;
                endcase
            end
            if (w_active) begin
                if (w_err) begin
                    r_halted <= 1'b1;
                end else begin
                    r_hdr_sent <= 1'b1;
                    r_pos      <= r_pos + 32'd1;
                    if (w_last) begin
                        r_halted <= 1'b1;
                    end
                    if (!w_same) begin
                        r_run_start <= w_start;
                    end
                    if (w_flush) begin
                        r_run_count <= '0;
                        r_bank      <= ~r_bank;
                    end else if (!w_same) begin
                        r_run_count <= w_cnt_inc;
                    end
                end
            end
        end
    end

    a_no_cmd_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("command issued after the patch ended");

    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.flush |-> (o_cmd.count != '0) && (o_cmd.count <= LIMIT))
        else $error("flushed run has a bad length");

    a_open_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count < LIMIT)
        else $error("open run reached the limit without a flush");

endmodule

>>> rtl/bdpre_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of emit commands between front end and back end.
// ----------------------------------------------------------------------------
module bdpre_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bdpre_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output bdpre_pkg::t_cmd o_cmd,
    output logic            o_empty
);

    bdpre_pkg::t_cmd r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_fill;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/bdpre_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patch encoder back end
// Sequences each command into patch bytes through an output register, one per
// cycle unless stalled: header, record offset and length, run bytes, end marker.
// ----------------------------------------------------------------------------
module bdpre_back #(
    parameter int IDX_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  bdpre_pkg::t_cmd     i_cmd,
    output logic                o_pop,
    output logic [IDX_W:0]      o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output bdpre_pkg::t_release o_release,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_end_of_batch,
    output logic                o_end_of_patch,
    output logic                o_error_flag
);

    localparam logic [bdpre_pkg::CNT_W-1:0] HDR_LAST  = bdpre_pkg::CNT_W'(bdpre_pkg::HDR_BYTES - 1);
    localparam logic [bdpre_pkg::CNT_W-1:0] WORD_LAST = bdpre_pkg::CNT_W'(bdpre_pkg::WORD_BYTES - 1);
    localparam logic [bdpre_pkg::CNT_W-1:0] EOF_LAST  = bdpre_pkg::CNT_W'(bdpre_pkg::EOF_BYTES - 1);

    bdpre_pkg::t_bk_state        r_state;
    bdpre_pkg::t_bk_state        n_state;
    logic [bdpre_pkg::CNT_W-1:0] r_cnt;
    logic [bdpre_pkg::CNT_W-1:0] n_cnt;
    bdpre_pkg::t_cmd             r_cmd;
    bdpre_pkg::t_cmd             n_cmd;

    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_eob;
    logic       r_o_eop;
    logic       r_o_err;

    logic       w_adv;
    logic       w_emit;
    logic [7:0] w_byte;
    logic       w_eob;
    logic       w_eop;
    logic       w_err;

    assign w_adv = !r_o_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        o_pop     = 1'b0;
        o_release = '{valid: 1'b0, bank: r_cmd.bank};
        w_emit    = 1'b0;
        w_byte    = 8'h00;
        w_eob     = 1'b0;
        w_eop     = 1'b0;
        w_err     = 1'b0;
        unique case (r_state)
            bdpre_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_cnt = '0;
                    if (i_cmd.err) begin
                        n_state = bdpre_pkg::ST_ERR;
                    end else if (i_cmd.hdr) begin
                        n_state = bdpre_pkg::ST_HDR;
                    end else if (i_cmd.flush) begin
                        n_state = bdpre_pkg::ST_OFS;
                    end else begin
                        n_state = bdpre_pkg::ST_EOF;
                    end
                end
            end
            bdpre_pkg::ST_ERR: begin
                if (w_adv) begin
                    w_emit  = 1'b1;
                    w_err   = 1'b1;
                    w_eop   = 1'b1;
                    w_eob   = 1'b1;
                    n_state = bdpre_pkg::ST_IDLE;
                end
            end
            bdpre_pkg::ST_HDR: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = bdpre_pkg::hdr_char(r_cnt[2:0]);
                    n_cnt  = r_cnt + bdpre_pkg::CNT_W'(1);
                    if (r_cnt == HDR_LAST) begin
                        n_cnt = '0;
                        if (r_cmd.flush) begin
                            n_state = bdpre_pkg::ST_OFS;
                        end else if (r_cmd.eof) begin
                            n_state = bdpre_pkg::ST_EOF;
                        end else begin
                            w_eob   = 1'b1;
                            n_state = bdpre_pkg::ST_IDLE;
                        end
                    end
                end
            end
            bdpre_pkg::ST_OFS: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = bdpre_pkg::word_byte(r_cmd.start, r_cnt[1:0]);
                    n_cnt  = r_cnt + bdpre_pkg::CNT_W'(1);
                    if (r_cnt == WORD_LAST) begin
                        n_cnt   = '0;
                        n_state = bdpre_pkg::ST_LEN;
                    end
                end
            end
            bdpre_pkg::ST_LEN: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = bdpre_pkg::word_byte(
                        {{(bdpre_pkg::WORD_W - bdpre_pkg::CNT_W){1'b0}}, r_cmd.count},
                        r_cnt[1:0]);
                    n_cnt  = r_cnt + bdpre_pkg::CNT_W'(1);
                    if (r_cnt == WORD_LAST) begin
                        n_cnt   = '0;
                        n_state = bdpre_pkg::ST_DATA;
                    end
                end
            end
            bdpre_pkg::ST_DATA: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = i_rd_data;
                    n_cnt  = r_cnt + bdpre_pkg::CNT_W'(1);
                    if (r_cnt == r_cmd.count - bdpre_pkg::CNT_W'(1)) begin
                        n_cnt           = '0;
                        o_release.valid = 1'b1;
                        if (r_cmd.eof) begin
                            n_state = bdpre_pkg::ST_EOF;
                        end else begin
                            w_eob   = 1'b1;
                            n_state = bdpre_pkg::ST_IDLE;
                        end
                    end
                end
            end
            bdpre_pkg::ST_EOF: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    w_byte = bdpre_pkg::eof_char(r_cnt[1:0]);
                    n_cnt  = r_cnt + bdpre_pkg::CNT_W'(1);
                    if (r_cnt == EOF_LAST) begin
                        n_cnt   = '0;
                        w_eob   = 1'b1;
                        w_eop   = 1'b1;
                        n_state = bdpre_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = bdpre_pkg::ST_IDLE;
            end
        endcase
    end

    // The read address follows the next count, so the registered read data
    // lines up with the run byte being sent in the data state.
    assign o_rd_addr = {r_cmd.bank, n_cnt[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bdpre_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_adv) begin
                r_o_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (w_adv && w_emit) begin
            r_o_byte <= w_byte;
            r_o_eob  <= w_eob;
            r_o_eop  <= w_eop;
            r_o_err  <= w_err;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_end_of_batch = r_o_eob;
    assign o_end_of_patch = r_o_eop;
    assign o_error_flag   = r_o_err;

    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err |-> r_o_eob && r_o_eop)
        else $error("error beat does not end the patch");

    a_eop_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_eop |-> r_o_eob)
        else $error("end of patch without end of batch");

    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bdpre_pkg::ST_DATA |-> r_cnt < r_cmd.count)
        else $error("run byte index past the run length");

endmodule
